### rtl/lcg48_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcg48_pkg
// Shared types and constants for the 48-bit LCG random generator.
// ----------------------------------------------------------------------------
package lcg48_pkg;

	localparam logic [47:0] LCG_MULT   = 48'h0005DEECE66D;
	localparam logic [23:0] LCG_MULT_L = 24'hECE66D;
	localparam logic [23:0] LCG_MULT_H = 24'h0005DE;
	localparam logic [47:0] LCG_ADD    = 48'h00000000000B;
	localparam int          DIV_STEPS  = 31;

	typedef enum logic [1:0] {
		KIND_RAW   = 2'd0,
		KIND_ABS   = 2'd1,
		KIND_BOUND = 2'd2,
		KIND_LONG  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MOP_NONE,
		MOP_LOW,
		MOP_CROSS_A,
		MOP_CROSS_B
	} mop_t;

	typedef enum logic [2:0] {
		RES_RAW,
		RES_ABS,
		RES_POW,
		RES_MOD,
		RES_LONG,
		RES_NEG1
	} res_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_M0,
		S_M1,
		S_M2,
		S_M3,
		S_EVAL,
		S_POW,
		S_DIV,
		S_CHK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic     capture_in;
		mop_t     mop;
		logic     commit;
		logic     save_hi;
		logic     pow_en;
		logic     div_start;
		logic     div_step;
		logic     res_load;
		res_sel_t res_sel;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  bound_ok;
		logic  is_pow2;
		logic  div_last;
		logic  reject;
		logic  out_free;
	} sts_t;

endpackage
`default_nettype wire

### rtl/lcg48_random_generator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcg48_random_generator_top
// 48-bit linear congruential generator, java.util.Random draw kinds.
// One word in flight. Raw and absolute draw: three multiply passes on one 24x24
// unit, commit, evaluate, output; power-of-two bound adds a multiply, bound not
// positive goes to output, a 64-bit draw steps twice; other bounds run the
// 31-step bit-serial remainder unit and redraw on each rejected attempt.
// Reset: state loaded with the scrambled zero seed, output empty.
// ----------------------------------------------------------------------------
module lcg48_random_generator_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [47:0]        cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         kind,
	input  wire logic [5:0]         bits,
	input  wire logic signed [31:0] bound,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [63:0]      value
);
	import lcg48_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lcg48_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lcg48_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.kind      (kind),
		.bits      (bits),
		.bound     (bound),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.value     (value)
	);

endmodule
`default_nettype wire

### rtl/lcg48_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcg48_dpath
// State register, shared 24x24 multiplier, divider and result registers.
// ----------------------------------------------------------------------------
module lcg48_dpath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [47:0]        cfg_wdata,
	input  wire logic [1:0]         kind,
	input  wire logic [5:0]         bits,
	input  wire logic signed [31:0] bound,
	input  wire lcg48_pkg::cmd_t    cmd,
	output lcg48_pkg::sts_t         sts,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [63:0]      value
);
	import lcg48_pkg::*;

	logic [47:0] lcg_q;
	logic [47:0] acc_q;
	logic [47:0] prod_q;
	logic [1:0]  kind_q;
	logic [5:0]  bits_q;
	logic [31:0] bound_q;
	logic [31:0] hi_q;
	logic [61:0] pow_q;
	logic [30:0] dvd_q;
	logic [30:0] rem_q;
	logic [30:0] r_q;
	logic [4:0]  cnt_q;
	logic [63:0] res64_q;
	logic        out_valid_q;
	logic [63:0] value_q;

	logic [23:0] mul_a, mul_b;
	logic [47:0] mul_p;
	logic [31:0] top32;
	logic [5:0]  nb;
	logic [31:0] raw_w, abs_w, chk_w;
	logic [31:0] div_t;
	logic [31:0] res_w;

	always_comb begin
		unique case (cmd.mop)
			MOP_LOW:     begin mul_a = lcg_q[23:0];  mul_b = LCG_MULT_L; end
			MOP_CROSS_A: begin mul_a = lcg_q[47:24]; mul_b = LCG_MULT_L; end
			MOP_CROSS_B: begin mul_a = lcg_q[23:0];  mul_b = LCG_MULT_H; end
			default:     begin mul_a = '0;           mul_b = '0;         end
		endcase
		mul_p = mul_a * mul_b;
	end

	assign top32 = lcg_q[47:16];
	assign nb    = (bits_q > 6'd32) ? 6'd32 : bits_q;
	assign raw_w = top32 >> (6'd32 - nb);
	assign abs_w = top32[31] ? (32'd0 - top32) : top32;
	assign div_t = {rem_q, dvd_q[30]};
	assign chk_w = {1'b0, r_q} - {1'b0, rem_q} + bound_q - 32'd1;

	always_comb begin
		case (cmd.res_sel)
			RES_RAW:  res_w = raw_w;
			RES_ABS:  res_w = abs_w;
			RES_POW:  res_w = {1'b0, pow_q[61:31]};
			RES_MOD:  res_w = {1'b0, rem_q};
			default:  res_w = 32'hFFFF_FFFF;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcg_q <= LCG_MULT;
		end else if (cfg_we) begin
			lcg_q <= cfg_wdata ^ LCG_MULT;
		end else if (cmd.commit) begin
			lcg_q <= acc_q + {prod_q[23:0], 24'd0};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture_in) begin
			kind_q  <= kind;
			bits_q  <= bits;
			bound_q <= bound;
		end
		if (cmd.mop != MOP_NONE) prod_q <= mul_p;
		if (cmd.mop == MOP_CROSS_A) acc_q <= prod_q + LCG_ADD;
		if (cmd.mop == MOP_CROSS_B) acc_q <= acc_q + {prod_q[23:0], 24'd0};
		if (cmd.save_hi) hi_q <= top32;
		if (cmd.pow_en) pow_q <= bound_q[30:0] * lcg_q[47:17];
		if (cmd.div_start) begin
			dvd_q <= lcg_q[47:17];
			r_q   <= lcg_q[47:17];
			rem_q <= '0;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[29:0], 1'b0};
			rem_q <= (div_t >= bound_q) ? 31'(div_t - bound_q) : div_t[30:0];
			cnt_q <= cnt_q + 5'd1;
		end
		if (cmd.res_load) begin
			if (cmd.res_sel == RES_LONG)
				res64_q <= {hi_q, 32'd0} + {{32{top32[31]}}, top32};
			else
				res64_q <= {{32{res_w[31]}}, res_w};
		end
		if (cmd.out_load) value_q <= res64_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.kind     = kind_t'(kind_q);
	assign sts.bound_ok = !bound_q[31] && (bound_q != 32'd0);
	assign sts.is_pow2  = (bound_q & (32'd0 - bound_q)) == bound_q;
	assign sts.div_last = (cnt_q == 5'(DIV_STEPS - 1));
	assign sts.reject   = chk_w[31];
	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign value        = value_q;

endmodule
`default_nettype wire

### rtl/lcg48_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcg48_ctrl
// Sequencer for LCG steps, bounded-draw division and result hand-off.
// ----------------------------------------------------------------------------
module lcg48_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire lcg48_pkg::sts_t sts,
	output lcg48_pkg::cmd_t      cmd
);
	import lcg48_pkg::*;

	state_t st_q, st_nxt;
	logic   half_q;

	always_comb begin
		st_nxt = st_q;
		unique case (st_q)
			S_IDLE: if (in_valid) st_nxt = S_M0;
			S_M0:   st_nxt = (sts.kind == KIND_BOUND && !sts.bound_ok) ? S_DONE : S_M1;
			S_M1:   st_nxt = S_M2;
			S_M2:   st_nxt = S_M3;
			S_M3:   st_nxt = S_EVAL;
			S_EVAL: begin
				unique case (sts.kind)
					KIND_BOUND: st_nxt = sts.is_pow2 ? S_POW : S_DIV;
					KIND_LONG:  st_nxt = half_q ? S_DONE : S_M0;
					default:    st_nxt = S_DONE;
				endcase
			end
			S_POW:  st_nxt = S_DONE;
			S_DIV:  if (sts.div_last) st_nxt = S_CHK;
			S_CHK:  st_nxt = sts.reject ? S_M0 : S_DONE;
			S_DONE: if (sts.out_free) st_nxt = S_IDLE;
			default: st_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.mop  = MOP_NONE;
		cmd.res_sel = RES_NEG1;
		in_stall = 1'b1;
		unique case (st_q)
			S_IDLE: begin
				in_stall       = 1'b0;
				cmd.capture_in = in_valid;
			end
			S_M0: begin
				cmd.mop = MOP_LOW;
				cmd.res_load = (sts.kind == KIND_BOUND && !sts.bound_ok);
			end
			S_M1:   cmd.mop = MOP_CROSS_A;
			S_M2:   cmd.mop = MOP_CROSS_B;
			S_M3:   cmd.commit = 1'b1;
			S_EVAL: begin
				unique case (sts.kind)
					KIND_RAW: begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = RES_RAW;
					end
					KIND_ABS: begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = RES_ABS;
					end
					KIND_BOUND: begin
						cmd.pow_en    = sts.is_pow2;
						cmd.div_start = !sts.is_pow2;
					end
					default: begin
						cmd.save_hi  = !half_q;
						cmd.res_load = half_q;
						cmd.res_sel  = RES_LONG;
					end
				endcase
			end
			S_POW: begin
				cmd.res_load = 1'b1;
				cmd.res_sel  = RES_POW;
			end
			S_DIV:  cmd.div_step = 1'b1;
			S_CHK: begin
				cmd.res_load = !sts.reject;
				cmd.res_sel  = RES_MOD;
			end
			S_DONE: cmd.out_load = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			half_q <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (st_q == S_IDLE)
				half_q <= 1'b0;
			else if (st_q == S_EVAL && sts.kind == KIND_LONG)
				half_q <= 1'b1;
		end
	end

endmodule
`default_nettype wire
